FILE: design/stxfr_pkg.sv
// Shared types, codes and constants for the framed packet receiver and checker.
`timescale 1ns / 1ps
package stxfr_pkg;

  localparam int LENGTH_BITS_DEFAULT = 20;

  localparam int BYTE_W   = 8;
  localparam int CHECK_W  = 16;
  localparam int LEN_W    = 32;
  localparam int FLEN_W   = 20;
  localparam int CMD_W    = 8;
  localparam int MAXLEN_W = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0]   START_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0]   ZERO_BYTE  = 8'h00;
  localparam logic [CHECK_W-1:0]  CHECK_POLY = 16'h1021;
  localparam logic [CHECK_W-1:0]  CHECK_TOP  = 16'h8000;
  localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET = 20'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED_COMMAND = 2'd0,
    REG_MAX_LENGTH       = 2'd1,
    REG_EXACT_LENGTH     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TYPE     = 3'd1,
    ST_LONG     = 3'd2,
    ST_CMD      = 3'd3,
    ST_CHECK    = 3'd4,
    ST_MISMATCH = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  typedef struct packed {
    logic              end_of_frame;
    logic [BYTE_W-1:0] payload_byte;
    status_t           status;
    logic [FLEN_W-1:0] frame_length;
  } result_t;

endpackage

FILE: design/stxfr_chk.sv
// Single-step running check update over one byte.
`timescale 1ns / 1ps
module stxfr_chk import stxfr_pkg::*; (
  input  logic [CHECK_W-1:0] chk_in,
  input  logic [BYTE_W-1:0]  data,
  output logic [CHECK_W-1:0] chk_out
);

  logic [CHECK_W-1:0] mixed;

  always_comb begin
    mixed = chk_in ^ {data, ZERO_BYTE};
    // one conditional shift only, not a full byte-wide CRC
    if ((mixed & CHECK_TOP) != '0) begin
      chk_out = {mixed[CHECK_W-2:0], 1'b0} ^ CHECK_POLY;
    end else begin
      chk_out = {mixed[CHECK_W-2:0], 1'b0};
    end
  end

endmodule

FILE: design/stxfr_core.sv
// Frame parser: hunt, header checks, payload pass-through and trailer check.
`timescale 1ns / 1ps
module stxfr_core import stxfr_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 take,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 res_valid,
  output result_t              res
);

  localparam logic [LEN_W-1:0]  LEN_MASK = LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [FLEN_W-1:0] FLEN_MASK = LEN_MASK[FLEN_W-1:0];

  logic [CMD_W-1:0]    expected_command;
  logic [MAXLEN_W-1:0] max_length;
  logic                exact_length;

  phase_t                 phase, phase_next;
  logic [2:0]             hdr_idx, hdr_idx_next;
  logic [BYTE_W-1:0]      hdr_type, hdr_type_next;
  logic [LEN_W-1:0]       ann_len, ann_len_next;
  logic [LENGTH_BITS-1:0] pay_cnt, pay_cnt_next;
  logic [CHECK_W-1:0]     run_chk, run_chk_next;
  logic [CHECK_W-1:0]     rcv_chk, rcv_chk_next;
  logic                   trl_nz, trl_nz_next;

  logic [CHECK_W-1:0]     chk_upd;
  logic [LEN_W-1:0]       limit;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic                   trl_nz_now;

  stxfr_chk u_chk (
    .chk_in  (run_chk),
    .data    (rx_byte),
    .chk_out (chk_upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= '0;
      max_length       <= MAX_LENGTH_RESET;
      exact_length     <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EXPECTED_COMMAND: expected_command <= cfg_data[CMD_W-1:0];
        REG_MAX_LENGTH:       max_length       <= cfg_data[MAXLEN_W-1:0];
        REG_EXACT_LENGTH:     exact_length     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign limit      = {{(LEN_W-MAXLEN_W){1'b0}}, max_length} & LEN_MASK;
  assign cnt_inc    = pay_cnt + LENGTH_BITS'(1);
  assign trl_nz_now = trl_nz || (rx_byte != ZERO_BYTE);

  always_comb begin
    phase_next    = phase;
    hdr_idx_next  = hdr_idx;
    hdr_type_next = hdr_type;
    ann_len_next  = ann_len;
    pay_cnt_next  = pay_cnt;
    run_chk_next  = run_chk;
    rcv_chk_next  = rcv_chk;
    trl_nz_next   = trl_nz;
    res_valid        = 1'b0;
    res.end_of_frame = 1'b1;
    res.payload_byte = '0;
    res.status       = ST_OK;
    res.frame_length = ann_len[FLEN_W-1:0] & FLEN_MASK;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) begin
          phase_next    = PH_HEADER;
          hdr_idx_next  = '0;
          hdr_type_next = '0;
          ann_len_next  = '0;
          pay_cnt_next  = '0;
          run_chk_next  = '0;
          rcv_chk_next  = '0;
          trl_nz_next   = 1'b0;
        end
      end

      PH_HEADER: begin
        run_chk_next = chk_upd;
        hdr_idx_next = hdr_idx + 3'd1;
        if (hdr_idx == 3'd0) begin
          hdr_type_next = rx_byte;
        end else if (hdr_idx <= 3'd4) begin
          unique case (hdr_idx[1:0])
            2'd1:    ann_len_next[7:0]   = rx_byte;
            2'd2:    ann_len_next[15:8]  = rx_byte;
            2'd3:    ann_len_next[23:16] = rx_byte;
            default: ann_len_next[31:24] = rx_byte;
          endcase
        end else begin
          // command byte: first failing check wins, in order type, length, command
          hdr_idx_next = '0;
          pay_cnt_next = '0;
          if (hdr_type != ZERO_BYTE) begin
            res_valid  = 1'b1;
            res.status = ST_TYPE;
            phase_next = PH_HUNT;
          end else if (ann_len > limit) begin
            res_valid  = 1'b1;
            res.status = ST_LONG;
            phase_next = PH_HUNT;
          end else if (rx_byte != expected_command) begin
            res_valid  = 1'b1;
            res.status = ST_CMD;
            phase_next = PH_HUNT;
          end else if (ann_len == '0) begin
            phase_next = PH_TRAILER;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end

      PH_PAYLOAD: begin
        run_chk_next     = chk_upd;
        pay_cnt_next     = cnt_inc;
        res_valid        = 1'b1;
        res.end_of_frame = 1'b0;
        res.payload_byte = rx_byte;
        res.frame_length = '0;
        if (cnt_inc == ann_len[LENGTH_BITS-1:0]) begin
          phase_next   = PH_TRAILER;
          hdr_idx_next = '0;
        end
      end

      default: begin
        hdr_idx_next = hdr_idx + 3'd1;
        if (hdr_idx == 3'd0) begin
          rcv_chk_next = {rx_byte, ZERO_BYTE};
        end else if (hdr_idx == 3'd1) begin
          rcv_chk_next[BYTE_W-1:0] = rx_byte;
        end else begin
          trl_nz_next = trl_nz_now;
          if (hdr_idx >= 3'd3) begin
            res_valid    = 1'b1;
            phase_next   = PH_HUNT;
            hdr_idx_next = '0;
            if (rcv_chk != run_chk || trl_nz_now) begin
              res.status = ST_CHECK;
            end else if (exact_length && ann_len != limit) begin
              res.status = ST_MISMATCH;
            end else begin
              res.status = ST_OK;
            end
          end
        end
      end
    endcase

    if (!take) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      hdr_idx  <= '0;
      hdr_type <= '0;
      ann_len  <= '0;
      pay_cnt  <= '0;
      run_chk  <= '0;
      rcv_chk  <= '0;
      trl_nz   <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      hdr_idx  <= hdr_idx_next;
      hdr_type <= hdr_type_next;
      ann_len  <= ann_len_next;
      pay_cnt  <= pay_cnt_next;
      run_chk  <= run_chk_next;
      rcv_chk  <= rcv_chk_next;
      trl_nz   <= trl_nz_next;
    end
  end

endmodule

FILE: design/stxfr_outbuf.sv
// Two-entry result buffer between the parser and the output channel.
`timescale 1ns / 1ps
module stxfr_outbuf import stxfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  result_t    slot0, slot1;
  logic [1:0] cnt, cnt_next;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign has_room  = (cnt != 2'd2);
  assign head      = slot0;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // advance the queue; a push only lands here when one entry was held
      if (cnt == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= push_data;
      end
      if (push && cnt == 2'd2) begin
        slot1 <= push_data;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

FILE: design/stx_frame_receiver_checker.sv
// Top level of the length-framed packet receiver and checker.
// Output: each result is registered in the result buffer when its byte is transferred.
// Throughput: one byte per cycle; in_ready drops only when both result buffer
// entries are held, which the output side's ready sets.
// Reset (rst, synchronous): parser back to hunting, result buffer empty,
// registers to command 0, max length 512, exact length off.
`timescale 1ns / 1ps
module stx_frame_receiver_checker import stxfr_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 end_of_frame,
  output logic [BYTE_W-1:0]    payload_byte,
  output logic [2:0]           status,
  output logic [FLEN_W-1:0]    frame_length
);

  logic    take;
  logic    res_valid;
  result_t res;
  result_t head;

  assign take = in_valid && in_ready;

  stxfr_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  stxfr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign end_of_frame = head.end_of_frame;
  assign payload_byte = head.payload_byte;
  assign status       = head.status;
  assign frame_length = head.frame_length;

endmodule
